// ----- sv/adaptive_byte_rank_table_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the adaptive byte rank table
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_BYTE_RANK_TABLE_DEFINES_SVH
`define ADAPTIVE_BYTE_RANK_TABLE_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define ABRT_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ABRT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/abrt_pkg.sv -----
// ----------------------------------------------------------------------------
// abrt_pkg
// Types, register codes and table constants of the adaptive byte rank table.
// ----------------------------------------------------------------------------
`default_nettype none

package abrt_pkg;

	// Register decode: one bit of paddr selects the register.
	localparam logic REG_COUNT_LIMIT  = 1'b0;
	localparam logic REG_INIT_PATTERN = 1'b1;

	// Initial contents codes; the unused code loads the identity.
	localparam logic [1:0] PAT_NEGATED  = 2'd0;
	localparam logic [1:0] PAT_IDENTITY = 2'd1;
	localparam logic [1:0] PAT_REGROUP  = 2'd2;

	localparam logic [7:0] LIMIT_RESET = 8'hff;

	typedef enum logic [2:0] {
		S_SWEEP,
		S_IDLE,
		S_RD1,
		S_RERD,
		S_RD2,
		S_RD3,
		S_WR
	} abrt_state_t;

	// Count of a slot after a regroup: 7 for the first group of 32, 0 for the last.
	function automatic logic [7:0] group_count(input logic [7:0] slot);
		return {5'b0, 3'(3'd7 - slot[7:5])};
	endfunction

	// First slot of the group that holds count c (c below 8).
	function automatic logic [7:0] group_start(input logic [2:0] c);
		return {3'(3'd7 - c), 5'b0};
	endfunction

endpackage

`default_nettype wire

// ----- sv/adaptive_byte_rank_table.sv -----
// ----------------------------------------------------------------------------
// adaptive_byte_rank_table
// Adaptive byte reordering table: lookup, swap with group slot, count update.
// ----------------------------------------------------------------------------
// A lookup runs S_RD1, S_RD2, S_RD3, S_WR (no regroup); S_WR loads the result.
// A new lookup waits for S_WR or S_IDLE, set by the dependent read chain
//   entry -> slot pointer -> target entry and the single entry write port.
// A lookup that hits the count limit first sweeps the table to regroup it.
// Reset and every register write run a load pass over all 256 slots of both
//   memories; no request is taken until it ends.
`default_nettype none
`include "adaptive_byte_rank_table_defines.svh"

module adaptive_byte_rank_table import abrt_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// lookup request
	input  wire logic        req_valid,
	output logic             req_ready,
	input  wire logic [7:0]  index,
	// lookup result
	output logic             rsp_valid,
	input  wire logic        rsp_ready,
	output logic [7:0]       value,
	output logic             regrouped,
	// register port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	// ------------------------------------------------------------------
	// Memories: entry store {value, count} and slot pointer per count
	// ------------------------------------------------------------------
	logic [15:0] ent_mem [256];
	logic [7:0]  ptr_mem [256];

	logic [15:0] ent_rd_q;
	logic [7:0]  ptr_rd_q;

	logic [7:0]  ent_ra;
	logic [7:0]  ent_wa;
	logic [15:0] ent_wd;
	logic        ent_we_hi;
	logic        ent_we_lo;
	logic [7:0]  ptr_ra;
	logic [7:0]  ptr_wa;
	logic [7:0]  ptr_wd;
	logic        ptr_we;

	// ------------------------------------------------------------------
	// Control and datapath registers
	// ------------------------------------------------------------------
	abrt_state_t state_q, state_d;

	logic [7:0]  limit_q;
	logic [1:0]  pat_q;
	logic [7:0]  swp_cnt_q;
	logic        swp_load_q;  // 1: pattern load, 0: regroup inside a lookup
	logic        rsp_valid_q;
	logic [7:0]  value_q;
	logic        regrouped_q;

	logic [7:0]  idx_q;       // looked-up slot
	logic [15:0] ent_q;       // entry at the looked-up slot
	logic [7:0]  tgt_q;       // slot named by the pointer
	logic        rg_q;        // this lookup already regrouped
	logic        fwd_q;       // last target write hits the new index
	logic [15:0] fwd_data_q;

	// ------------------------------------------------------------------
	// Decode and shared terms
	// ------------------------------------------------------------------
	logic        cfg_wr;
	logic        out_free;
	logic        req_xfer;
	logic [15:0] cur_ent;
	logic        over_limit;
	logic [15:0] tgt_new;
	logic        swp_last;

	assign cfg_wr     = psel && penable && pwrite;
	assign out_free   = !rsp_valid_q || rsp_ready;
	assign req_xfer   = req_valid && req_ready;
	// Take the target write of the previous lookup if it hit this slot.
	assign cur_ent    = fwd_q ? fwd_data_q : ent_rd_q;
	assign over_limit = !rg_q && (cur_ent[7:0] >= limit_q);
	assign tgt_new    = {ent_q[15:8], 8'(ent_q[7:0] + 8'd1)};
	assign swp_last   = (swp_cnt_q == 8'hff);

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_INIT_PATTERN) ? {30'b0, pat_q} : {24'b0, limit_q};

	assign rsp_valid = rsp_valid_q;
	assign value     = value_q;
	assign regrouped = regrouped_q;

	// ------------------------------------------------------------------
	// Next state
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_SWEEP: begin
				if (swp_last) begin
					state_d = swp_load_q ? S_IDLE : S_RERD;
				end
			end
			S_IDLE: begin
				if (req_xfer) begin
					state_d = S_RD1;
				end
			end
			S_RD1: begin
				state_d = over_limit ? S_SWEEP : S_RD2;
			end
			S_RERD: begin
				state_d = S_RD1;
			end
			S_RD2: begin
				state_d = S_RD3;
			end
			S_RD3: begin
				state_d = S_WR;
			end
			S_WR: begin
				if (req_xfer) begin
					state_d = S_RD1;
				end else if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		// A register write restarts the load pass.
		if (cfg_wr) begin
			state_d = S_SWEEP;
		end
	end

	// ------------------------------------------------------------------
	// Outputs of the state machine: memory ports and handshake
	// ------------------------------------------------------------------
	always_comb begin
		ent_ra    = idx_q;
		ent_wa    = idx_q;
		ent_wd    = ent_rd_q;
		ent_we_hi = 1'b0;
		ent_we_lo = 1'b0;
		ptr_ra    = cur_ent[7:0];
		ptr_wa    = swp_cnt_q;
		ptr_wd    = 8'd0;
		ptr_we    = 1'b0;
		req_ready = 1'b0;
		unique case (state_q)
			S_SWEEP: begin
				// Load writes the whole entry, regroup only the count byte.
				ent_wa    = swp_cnt_q;
				ent_we_hi = swp_load_q;
				ent_we_lo = 1'b1;
				ent_wd[15:8] = ((pat_q == PAT_NEGATED) && swp_load_q) ?
					8'(8'd0 - swp_cnt_q) : swp_cnt_q;
				ent_wd[7:0]  = (!swp_load_q || (pat_q == PAT_REGROUP)) ?
					group_count(swp_cnt_q) : 8'd0;
				ptr_we = 1'b1;
				if ((!swp_load_q || (pat_q == PAT_REGROUP)) && (swp_cnt_q[7:3] == 5'd0)) begin
					ptr_wd = group_start(swp_cnt_q[2:0]);
				end
			end
			S_IDLE: begin
				ent_ra    = index;
				req_ready = !cfg_wr;
			end
			S_RD1: begin
				ptr_ra = cur_ent[7:0];
			end
			S_RERD: begin
				ent_ra = idx_q;
			end
			S_RD2: begin
				// Advance the group pointer, fetch the target entry.
				ptr_wa = ent_q[7:0];
				ptr_wd = 8'(ptr_rd_q + 8'd1);
				ptr_we = 1'b1;
				ent_ra = ptr_rd_q;
			end
			S_RD3: begin
				// Move the target entry into the looked-up slot.
				ent_wa    = idx_q;
				ent_wd    = ent_rd_q;
				ent_we_hi = 1'b1;
				ent_we_lo = 1'b1;
			end
			S_WR: begin
				// Drop the looked-up entry, count raised, into the target slot.
				ent_wa    = tgt_q;
				ent_wd    = tgt_new;
				ent_we_hi = 1'b1;
				ent_we_lo = 1'b1;
				ent_ra    = index;
				req_ready = out_free && !cfg_wr;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Memories: one write and one registered read each
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (ent_we_hi) begin
			ent_mem[ent_wa][15:8] <= ent_wd[15:8];
		end
		if (ent_we_lo) begin
			ent_mem[ent_wa][7:0] <= ent_wd[7:0];
		end
		ent_rd_q <= ent_mem[ent_ra];
	end

	always_ff @(posedge clk) begin
		if (ptr_we) begin
			ptr_mem[ptr_wa] <= ptr_wd;
		end
		ptr_rd_q <= ptr_mem[ptr_ra];
	end

	// ------------------------------------------------------------------
	// Control registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SWEEP;
			limit_q     <= LIMIT_RESET;
			pat_q       <= PAT_IDENTITY;
			swp_cnt_q   <= 8'd0;
			swp_load_q  <= 1'b1;
			rsp_valid_q <= 1'b0;
			rg_q        <= 1'b0;
			fwd_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr) begin
				if (paddr[2] == REG_COUNT_LIMIT) begin
					limit_q <= pwdata[7:0];
				end else begin
					pat_q <= pwdata[1:0];
				end
				swp_cnt_q  <= 8'd0;
				swp_load_q <= 1'b1;
			end else if (state_q == S_SWEEP) begin
				swp_cnt_q <= 8'(swp_cnt_q + 8'd1);
			end else if (state_q == S_RD1 && over_limit) begin
				swp_cnt_q  <= 8'd0;
				swp_load_q <= 1'b0;
			end

			if (req_xfer) begin
				rg_q <= 1'b0;
			end else if (state_q == S_RD1 && over_limit) begin
				rg_q <= 1'b1;
			end

			// Forward only across a transfer taken while the target is written.
			if (req_xfer) begin
				fwd_q <= (state_q == S_WR) && (index == tgt_q);
			end else if (state_q == S_RERD) begin
				fwd_q <= 1'b0;
			end

			if (state_q == S_WR && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Datapath registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			idx_q      <= index;
			fwd_data_q <= tgt_new;
		end
		if (state_q == S_RD1) begin
			ent_q <= cur_ent;
		end
		if (state_q == S_RD2) begin
			tgt_q <= ptr_rd_q;
		end
		if (state_q == S_WR && out_free) begin
			value_q     <= ent_q[15:8];
			regrouped_q <= rg_q;
		end
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`ABRT_ASSERT_NEXT(a_result_loads, (state_q == S_WR) && out_free, rsp_valid_q,
		"finished lookup did not present a result")
	`ABRT_ASSERT_SAME(a_regroup_count, (state_q == S_RD1) && rg_q, cur_ent[7:0] < 8'd8,
		"count after regroup exceeds seven")
	`ABRT_ASSERT_NEXT(a_sweep_ends, (state_q == S_SWEEP) && swp_last && !cfg_wr,
		(state_q == S_IDLE) || (state_q == S_RERD), "sweep did not end after last slot")
	`ABRT_ASSERT_SAME(a_no_req_in_sweep, state_q == S_SWEEP, !req_ready,
		"request taken during table sweep")

endmodule

`default_nettype wire
